>>> design/three_phase_pwm_compare_generator_top_defines.svh
// Assertion macros for the three-phase PWM compare generator checker.
`ifndef THREE_PHASE_PWM_COMPARE_GENERATOR_TOP_DEFINES_SVH
`define THREE_PHASE_PWM_COMPARE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPPCG_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delayed consequent, disabled while in reset.
`define TPPCG_ASSERT_LAT2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

>>> design/tppcg_pkg.sv
// Shared types and constants of the three-phase PWM compare generator.
`timescale 1ns / 1ps

package tppcg_pkg;

    localparam int ModWidth           = 16;
    localparam int SumWidth           = ModWidth + 1;
    localparam int CountBits          = 16;
    localparam int DeadWidth          = 12;
    localparam int ModFracBitsDefault = 14;

    localparam logic [CountBits-1:0] PeriodReset     = CountBits'(16384);
    localparam logic [CountBits-1:0] CompareMinReset = CountBits'(0);
    localparam logic [CountBits-1:0] CompareMaxReset = CountBits'(16384);
    localparam logic [DeadWidth-1:0] DeadbandReset   = DeadWidth'(0);

    typedef enum logic [1:0] {
        REG_PERIOD_COUNT = 2'd0,
        REG_COMPARE_MIN  = 2'd1,
        REG_COMPARE_MAX  = 2'd2,
        REG_DEADBAND     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CountBits-1:0] period_count;
        logic [CountBits-1:0] compare_min;
        logic [CountBits-1:0] compare_max;
        logic [DeadWidth-1:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic signed [ModWidth-1:0] mod_a;
        logic signed [ModWidth-1:0] mod_b;
        logic signed [ModWidth-1:0] mod_c;
    } in_t;

    typedef struct packed {
        logic [CountBits-1:0] one;
        logic [CountBits-1:0] two;
        logic [CountBits-1:0] three;
        logic [CountBits-1:0] four;
    } phase_edges_t;

    typedef struct packed {
        logic [CountBits-1:0] a_edge_one;
        logic [CountBits-1:0] a_edge_two;
        logic [CountBits-1:0] a_edge_three;
        logic [CountBits-1:0] a_edge_four;
        logic [CountBits-1:0] b_edge_one;
        logic [CountBits-1:0] b_edge_two;
        logic [CountBits-1:0] b_edge_three;
        logic [CountBits-1:0] b_edge_four;
        logic [CountBits-1:0] c_edge_one;
        logic [CountBits-1:0] c_edge_two;
        logic [CountBits-1:0] c_edge_three;
        logic [CountBits-1:0] c_edge_four;
    } out_t;

endpackage

>>> design/tppcg_zero_seq.sv
// Min-max zero-sequence sum: largest plus smallest of the three phases.
`timescale 1ns / 1ps

module tppcg_zero_seq
    import tppcg_pkg::*;
(
    input  in_t                        mods,
    output logic signed [SumWidth-1:0] sum
);

    logic signed [ModWidth-1:0] hi;
    logic signed [ModWidth-1:0] lo;
    logic signed [ModWidth-1:0] hi_ab;
    logic signed [ModWidth-1:0] lo_ab;

    always_comb
    begin
        hi_ab = (mods.mod_b > mods.mod_a) ? mods.mod_b : mods.mod_a;
        lo_ab = (mods.mod_b < mods.mod_a) ? mods.mod_b : mods.mod_a;
        hi    = (mods.mod_c > hi_ab) ? mods.mod_c : hi_ab;
        lo    = (mods.mod_c < lo_ab) ? mods.mod_c : lo_ab;
        sum   = SumWidth'(hi) + SumWidth'(lo);
    end

endmodule

>>> design/tppcg_phase.sv
// Per-phase duty, compare scaling, window clamp and the four switching points.
`timescale 1ns / 1ps

module tppcg_phase
    import tppcg_pkg::*;
#(
    parameter int MOD_FRAC_BITS = ModFracBitsDefault
)
(
    input  logic signed [ModWidth-1:0] x,
    input  logic signed [SumWidth-1:0] sum,
    input  cfg_t                       cfg,
    output phase_edges_t               edges
);

    // duty q = 2x - s + 2^(F+1), in units of 2^-(F+2)
    localparam int QBase = (MOD_FRAC_BITS + 3 > SumWidth + 2) ? MOD_FRAC_BITS + 3
                                                              : SumWidth + 2;
    localparam int QW    = QBase + 1;
    localparam int QcW   = MOD_FRAC_BITS + 3;
    localparam int PW    = QcW + CountBits;
    localparam int EW    = CountBits + 2;

    localparam logic signed [QW-1:0] QFull = QW'(64'd1 << (MOD_FRAC_BITS + 2));
    localparam logic signed [QW-1:0] QHalf = QW'(64'd1 << (MOD_FRAC_BITS + 1));
    localparam logic signed [EW-1:0] EMax  = EW'((64'd1 << CountBits) - 64'd1);

    logic signed [QW-1:0]      q;
    logic [QcW-1:0]            qc;
    logic [PW-1:0]             prod;
    logic [CountBits-1:0]      cmp;
    logic [CountBits-1:0]      cmp_win;
    logic signed [EW-1:0]      hv;
    logic signed [EW-1:0]      cv;
    logic signed [EW-1:0]      dv;
    logic signed [EW-1:0]      e1;
    logic signed [EW-1:0]      e2;
    logic signed [EW-1:0]      e3;
    logic signed [EW-1:0]      e4;

    function automatic logic [CountBits-1:0] sat_edge(input logic signed [EW-1:0] v);
        logic [CountBits-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > EMax)
        begin
            r = '1;
        end
        else
        begin
            r = v[CountBits-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        q = (QW'(x) <<< 1) - QW'(sum) + QHalf;
        priority if (q > QFull)
        begin
            qc = QFull[QcW-1:0];
        end
        else if (q < 0)
        begin
            qc = '0;
        end
        else
        begin
            qc = q[QcW-1:0];
        end

        prod = PW'(qc) * PW'(cfg.period_count);
        cmp  = prod[MOD_FRAC_BITS+2+CountBits-1:MOD_FRAC_BITS+2];

        // inverted window: a value above the upper bound gets the upper bound, else the lower
        priority if (cmp > cfg.compare_max)
        begin
            cmp_win = cfg.compare_max;
        end
        else if (cmp < cfg.compare_min)
        begin
            cmp_win = cfg.compare_min;
        end
        else
        begin
            cmp_win = cmp;
        end

        hv = EW'({1'b0, cfg.period_count[CountBits-1:1]});
        cv = EW'({1'b0, cmp_win[CountBits-1:1]});
        dv = EW'(cfg.deadband);

        e1 = hv - cv - dv;
        e2 = hv - cv + dv;
        e3 = hv + cv - dv;
        e4 = hv + cv + dv;

        edges.one   = sat_edge(e1);
        edges.two   = sat_edge(e2);
        edges.three = sat_edge(e3);
        edges.four  = sat_edge(e4);
    end

endmodule

>>> design/three_phase_pwm_compare_generator_top.sv
// Top level of the three-phase center-aligned PWM compare generator.
`timescale 1ns / 1ps

// Takes one item of three Q2.14 phase modulation values per start pulse and
// returns the twelve compare edges (four per phase) through the input register
// and the result register, marked by a one-cycle done strobe. A new item can
// start on every clock: busy stays low, and the input register and the result
// register each hold one item, so the throughput is one item per cycle. The result is
// shown for exactly one cycle; the receiver must take it then. Configuration
// writes are always ready and take effect on the next item; write them only
// while no item is in flight.
module three_phase_pwm_compare_generator_top
    import tppcg_pkg::*;
#(
    parameter int MOD_FRAC_BITS = ModFracBitsDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_t                  mods,
    output logic                 done,
    output out_t                 edges,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_index_t           cfg_index,
    input  logic [CountBits-1:0] cfg_data
);

    cfg_t                        cfg_reg;
    cfg_t                        cfg_next;
    logic                        valid_reg;
    in_t                         mods_reg;
    logic                        done_reg;
    out_t                        edges_reg;
    out_t                        edges_next;
    logic signed [SumWidth-1:0]  sum;
    phase_edges_t                pe_a;
    phase_edges_t                pe_b;
    phase_edges_t                pe_c;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PERIOD_COUNT: cfg_next.period_count = cfg_data;
                REG_COMPARE_MIN:  cfg_next.compare_min  = cfg_data;
                REG_COMPARE_MAX:  cfg_next.compare_max  = cfg_data;
                REG_DEADBAND:     cfg_next.deadband     = cfg_data[DeadWidth-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_count <= PeriodReset;
            cfg_reg.compare_min  <= CompareMinReset;
            cfg_reg.compare_max  <= CompareMaxReset;
            cfg_reg.deadband     <= DeadbandReset;
            valid_reg            <= 1'b0;
            done_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mods_reg <= mods;
        end
        if (valid_reg)
        begin
            edges_reg <= edges_next;
        end
    end

    tppcg_zero_seq u_zero_seq
    (
        .mods (mods_reg),
        .sum  (sum)
    );

    tppcg_phase #(.MOD_FRAC_BITS(MOD_FRAC_BITS)) u_phase_a
    (
        .x     (mods_reg.mod_a),
        .sum   (sum),
        .cfg   (cfg_reg),
        .edges (pe_a)
    );

    tppcg_phase #(.MOD_FRAC_BITS(MOD_FRAC_BITS)) u_phase_b
    (
        .x     (mods_reg.mod_b),
        .sum   (sum),
        .cfg   (cfg_reg),
        .edges (pe_b)
    );

    tppcg_phase #(.MOD_FRAC_BITS(MOD_FRAC_BITS)) u_phase_c
    (
        .x     (mods_reg.mod_c),
        .sum   (sum),
        .cfg   (cfg_reg),
        .edges (pe_c)
    );

    always_comb
    begin
        edges_next.a_edge_one   = pe_a.one;
        edges_next.a_edge_two   = pe_a.two;
        edges_next.a_edge_three = pe_a.three;
        edges_next.a_edge_four  = pe_a.four;
        edges_next.b_edge_one   = pe_b.one;
        edges_next.b_edge_two   = pe_b.two;
        edges_next.b_edge_three = pe_b.three;
        edges_next.b_edge_four  = pe_b.four;
        edges_next.c_edge_one   = pe_c.one;
        edges_next.c_edge_two   = pe_c.two;
        edges_next.c_edge_three = pe_c.three;
        edges_next.c_edge_four  = pe_c.four;
    end

    assign done  = done_reg;
    assign edges = edges_reg;

endmodule

>>> design/tppcg_checker.sv
// Port-level checker for the PWM compare generator, bound to the top level.
`timescale 1ns / 1ps
`include "three_phase_pwm_compare_generator_top_defines.svh"

module tppcg_checker
    import tppcg_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input out_t edges
);

    // every accepted item gives a result through the input and result registers
    `TPPCG_ASSERT_LAT2(a_latency, start && !busy, done, "accepted item gave no result")

    // no result without a matching accepted item before it
    `TPPCG_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, 2), "result without item")

    // edges are ordered around the half period for every phase
    `TPPCG_ASSERT_IMPLY(a_order_a, done, (edges.a_edge_one <= edges.a_edge_two) && (edges.a_edge_one <= edges.a_edge_three) && (edges.a_edge_two <= edges.a_edge_four) && (edges.a_edge_three <= edges.a_edge_four), "phase a edges out of order")
    `TPPCG_ASSERT_IMPLY(a_order_b, done, (edges.b_edge_one <= edges.b_edge_two) && (edges.b_edge_one <= edges.b_edge_three) && (edges.b_edge_two <= edges.b_edge_four) && (edges.b_edge_three <= edges.b_edge_four), "phase b edges out of order")
    `TPPCG_ASSERT_IMPLY(a_order_c, done, (edges.c_edge_one <= edges.c_edge_two) && (edges.c_edge_one <= edges.c_edge_three) && (edges.c_edge_two <= edges.c_edge_four) && (edges.c_edge_three <= edges.c_edge_four), "phase c edges out of order")

endmodule

bind three_phase_pwm_compare_generator_top tppcg_checker u_tppcg_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .edges (edges)
);

>>> dv/three_phase_pwm_compare_generator_top_tb.sv
// Self-checking testbench for the three-phase PWM compare generator top level.
`timescale 1ns / 1ps

module three_phase_pwm_compare_generator_top_tb;
    import tppcg_pkg::*;

    localparam int CycleLimit = 200000;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        cfg_index_t idx;
        logic [15:0] data;
        in_t        mods;
        bit         typed;
        out_t       want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_t                  mods;
    logic                 done;
    out_t                 edges;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_index_t           cfg_index;
    logic [CountBits-1:0] cfg_data;

    cfg_t      cur_cfg;
    out_t      expected_edges[$];
    stim_row_t directed_rows[$];
    int        mismatch_count;
    int        cycle_count;

    string field_name [12] = '{
        "a_edge_one", "a_edge_two", "a_edge_three", "a_edge_four",
        "b_edge_one", "b_edge_two", "b_edge_three", "b_edge_four",
        "c_edge_one", "c_edge_two", "c_edge_three", "c_edge_four"
    };

    three_phase_pwm_compare_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mods      (mods),
        .done      (done),
        .edges     (edges),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [15:0] sat_count(input longint v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // Zero-sequence removal, duty clamp, period scaling, window, four switching points.
    function automatic out_t predict_edges(input in_t m);
        longint       x [3];
        longint       hi, lo, s, q, cmp, half, hc, dt;
        phase_edges_t pe [3];
        x[0] = longint'($signed(m.mod_a));
        x[1] = longint'($signed(m.mod_b));
        x[2] = longint'($signed(m.mod_c));
        hi = x[0];
        lo = x[0];
        for (int p = 1; p < 3; p++)
        begin
            if (x[p] > hi)
                hi = x[p];
            if (x[p] < lo)
                lo = x[p];
        end
        s = hi + lo;
        half = longint'(cur_cfg.period_count) >> 1;
        dt = longint'(cur_cfg.deadband);
        for (int p = 0; p < 3; p++)
        begin
            q = 2 * x[p] - s + (64'sd1 <<< (ModFracBitsDefault + 1));
            if (q > (64'sd1 <<< (ModFracBitsDefault + 2)))
                q = 64'sd1 <<< (ModFracBitsDefault + 2);
            else if (q < 0)
                q = 0;
            cmp = (q * longint'(cur_cfg.period_count)) >> (ModFracBitsDefault + 2);
            // inverted window: a value above the upper bound gets the upper bound, else the lower
            if (cmp > longint'(cur_cfg.compare_max))
                cmp = longint'(cur_cfg.compare_max);
            else if (cmp < longint'(cur_cfg.compare_min))
                cmp = longint'(cur_cfg.compare_min);
            hc = cmp >> 1;
            pe[p].one   = sat_count(half - hc - dt);
            pe[p].two   = sat_count(half - hc + dt);
            pe[p].three = sat_count(half + hc - dt);
            pe[p].four  = sat_count(half + hc + dt);
        end
        return {pe[0], pe[1], pe[2]};
    endfunction

    function automatic in_t pack_mods(input int a, input int b, input int c);
        in_t m;
        m.mod_a = a[15:0];
        m.mod_b = b[15:0];
        m.mod_c = c[15:0];
        return m;
    endfunction

    function automatic phase_edges_t edge_set(input int e1, input int e2,
                                              input int e3, input int e4);
        phase_edges_t pe;
        pe.one   = e1[15:0];
        pe.two   = e2[15:0];
        pe.three = e3[15:0];
        pe.four  = e4[15:0];
        return pe;
    endfunction

    function automatic stim_row_t item_row(input int a, input int b, input int c);
        stim_row_t r;
        r.kind  = ROW_ITEM;
        r.idx   = REG_PERIOD_COUNT;
        r.data  = '0;
        r.mods  = pack_mods(a, b, c);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_index_t idx, input logic [15:0] data);
        stim_row_t r;
        r       = item_row(0, 0, 0);
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    function automatic in_t rand_mods();
        logic [15:0] pick [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000};
        logic [15:0] base;
        in_t m;
        case ($urandom_range(0, 3))
            0:
            begin
                m = in_t'(48'({$urandom, $urandom}));
            end
            1:
            begin
                m.mod_a = 16'($signed($urandom_range(0, 32768)) - 16384);
                m.mod_b = 16'($signed($urandom_range(0, 32768)) - 16384);
                m.mod_c = 16'($signed($urandom_range(0, 32768)) - 16384);
            end
            2:
            begin
                m.mod_a = pick[$urandom_range(0, 4)];
                m.mod_b = pick[$urandom_range(0, 4)];
                m.mod_c = pick[$urandom_range(0, 4)];
            end
            default:
            begin
                // nearly equal phases: zero sequence dominates
                base = 16'($urandom);
                m.mod_a = base;
                m.mod_b = base + 16'($urandom_range(0, 64)) - 16'd32;
                m.mod_c = base + 16'($urandom_range(0, 64)) - 16'd32;
            end
        endcase
        return m;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PERIOD_COUNT: cur_cfg.period_count = data;
            REG_COMPARE_MIN:  cur_cfg.compare_min  = data;
            REG_COMPARE_MAX:  cur_cfg.compare_max  = data;
            REG_DEADBAND:     cur_cfg.deadband     = data[DeadWidth-1:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input in_t m, input out_t want, input bit typed);
        start <= 1'b1;
        mods  <= m;
        do
            @(posedge clk);
        while (busy);
        expected_edges.push_back(typed ? want : predict_edges(m));
    endtask

    // Drop start and wait until every outstanding item has returned.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic pick_config(input int chunk);
        logic [15:0] p, lo_bound, hi_bound, dt_data;
        case (chunk % 4)
            0:
            begin
                p = 16'($urandom_range(1, 65535));
                lo_bound = 16'd0;
                hi_bound = 16'hFFFF;
                dt_data = 16'($urandom);
            end
            1:
            begin
                p = 16'($urandom_range(1, 4000));
                lo_bound = 16'($urandom_range(0, p / 4));
                hi_bound = 16'($urandom_range(p / 2, p));
                dt_data = 16'($urandom_range(0, 300));
            end
            2:
            begin
                case (chunk / 4)
                    0:
                    begin
                        p = 16'hFFFF;
                        lo_bound = 16'd0;
                        hi_bound = 16'hFFFF;
                        dt_data = 16'hFFFF;
                    end
                    1:
                    begin
                        p = 16'd1;
                        lo_bound = 16'hFFFF;
                        hi_bound = 16'd0;
                        dt_data = 16'd0;
                    end
                    default:
                    begin
                        p = 16'd0;
                        lo_bound = 16'd0;
                        hi_bound = 16'd0;
                        dt_data = 16'h0FFF;
                    end
                endcase
            end
            default:
            begin
                p = 16'($urandom);
                lo_bound = 16'($urandom);
                hi_bound = 16'($urandom);
                dt_data = 16'($urandom);
            end
        endcase
        write_reg(REG_PERIOD_COUNT, p);
        write_reg(REG_COMPARE_MIN, lo_bound);
        write_reg(REG_COMPARE_MAX, hi_bound);
        write_reg(REG_DEADBAND, dt_data);
    endtask

    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && done)
        begin
            if (expected_edges.size() == 0)
            begin
                report_mismatch($sformatf("result with no item outstanding: %h", edges));
            end
            else
            begin
                want = expected_edges.pop_front();
                for (int i = 0; i < 12; i++)
                begin
                    if (edges[191 - 16 * i -: 16] !== want[191 - 16 * i -: 16])
                        report_mismatch($sformatf("%s got %0d want %0d", field_name[i],
                            edges[191 - 16 * i -: 16], want[191 - 16 * i -: 16]));
                end
            end
        end
    end

    initial
    begin
        stim_row_t r;
        int        pct;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        mods      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PERIOD_COUNT;
        cfg_data  <= '0;
        mismatch_count = 0;
        cycle_count = 0;
        cur_cfg.period_count = PeriodReset;
        cur_cfg.compare_min  = CompareMinReset;
        cur_cfg.compare_max  = CompareMaxReset;
        cur_cfg.deadband     = DeadbandReset;

        // reset values: all zero gives half duty on every phase
        r = item_row(0, 0, 0);
        r.typed = 1'b1;
        r.want = {edge_set(4096, 4096, 12288, 12288), edge_set(4096, 4096, 12288, 12288),
                  edge_set(4096, 4096, 12288, 12288)};
        directed_rows.push_back(r);
        // field extremes: one phase full on, one full off, one at center
        r = item_row(32767, -32768, 0);
        r.typed = 1'b1;
        r.want = {edge_set(0, 0, 16384, 16384), edge_set(8192, 8192, 8192, 8192),
                  edge_set(4096, 4096, 12288, 12288)};
        directed_rows.push_back(r);
        directed_rows.push_back(item_row(-32768, -32768, -32768));
        directed_rows.push_back(item_row(32767, 32767, 32767));
        directed_rows.push_back(item_row(16384, -8192, -8192));
        directed_rows.push_back(item_row(-32768, 32767, 32767));
        // zero period, dead time written with bits above its width
        directed_rows.push_back(cfg_row(REG_PERIOD_COUNT, 16'd0));
        directed_rows.push_back(cfg_row(REG_DEADBAND, 16'hFFFF));
        r = item_row(12345, -23456, 777);
        r.typed = 1'b1;
        r.want = {edge_set(0, 4095, 0, 4095), edge_set(0, 4095, 0, 4095),
                  edge_set(0, 4095, 0, 4095)};
        directed_rows.push_back(r);
        // full scale period: edges saturate at the top
        directed_rows.push_back(cfg_row(REG_PERIOD_COUNT, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_COMPARE_MAX, 16'hFFFF));
        directed_rows.push_back(item_row(32767, -32768, 0));
        directed_rows.push_back(item_row(0, 0, 0));
        // inverted compare window
        directed_rows.push_back(cfg_row(REG_COMPARE_MIN, 16'd40000));
        directed_rows.push_back(cfg_row(REG_COMPARE_MAX, 16'd1000));
        directed_rows.push_back(cfg_row(REG_DEADBAND, 16'd0));
        directed_rows.push_back(cfg_row(REG_PERIOD_COUNT, 16'd16384));
        directed_rows.push_back(item_row(32767, -32768, 0));
        directed_rows.push_back(item_row(100, -100, 0));
        // minimum period
        directed_rows.push_back(cfg_row(REG_PERIOD_COUNT, 16'd1));
        directed_rows.push_back(cfg_row(REG_COMPARE_MIN, 16'd0));
        directed_rows.push_back(cfg_row(REG_COMPARE_MAX, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_DEADBAND, 16'd2048));
        directed_rows.push_back(item_row(32767, -32768, 0));
        // window active on both sides with dead time
        directed_rows.push_back(cfg_row(REG_PERIOD_COUNT, 16'd3000));
        directed_rows.push_back(cfg_row(REG_COMPARE_MIN, 16'd500));
        directed_rows.push_back(cfg_row(REG_COMPARE_MAX, 16'd2500));
        directed_rows.push_back(cfg_row(REG_DEADBAND, 16'd100));
        directed_rows.push_back(item_row(8000, -4000, -4000));
        directed_rows.push_back(item_row(1, 0, -1));
        directed_rows.push_back(item_row(-20000, 5000, 15000));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                quiesce();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                send_item(directed_rows[i].mods, directed_rows[i].want, directed_rows[i].typed);
            end
        end

        // sender idles 18%, then 49%, then never
        for (int chunk = 0; chunk < 12; chunk++)
        begin
            pct = (chunk < 4) ? 18 : ((chunk < 8) ? 49 : 0);
            quiesce();
            pick_config(chunk);
            for (int n = 0; n < 54; n++)
            begin
                // each cycle idles with the chunk's odds
                while ($urandom_range(0, 99) < pct)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                send_item(rand_mods(), '0, 1'b0);
            end
        end

        quiesce();
        repeat (4) @(posedge clk);
        if (expected_edges.size() != 0)
            report_mismatch($sformatf("%0d items never returned", expected_edges.size()));
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
